>>> rtl/apq_pkg.sv
`timescale 1ns / 1ps

package apq_pkg;

  localparam int unsigned PRIO_W = 3;
  localparam int unsigned CFG_W = 7;

  localparam logic [PRIO_W-1:0] TOP_PRIORITY = 3'd5;
  localparam logic [PRIO_W-1:0] ZERO_PRIORITY = 3'd0;
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_AGE    = 2'd2,
    KIND_PURGE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PUT,
    ST_DONE
  } state_e;

  function automatic logic [PRIO_W-1:0] sat_prio(input logic [PRIO_W-1:0] p);
    sat_prio = (p > TOP_PRIORITY) ? TOP_PRIORITY : p;
  endfunction

endpackage

>>> rtl/apq_if.sv
`timescale 1ns / 1ps

interface apq_req_if #(
  parameter int unsigned TAG_BITS = 16
);
  logic                        valid;
  logic                        ready;
  apq_pkg::kind_e              kind;
  logic [TAG_BITS-1:0]         msg_tag;
  logic [apq_pkg::PRIO_W-1:0]  msg_priority;

  modport source (output valid, kind, msg_tag, msg_priority, input ready);
  modport sink (input valid, kind, msg_tag, msg_priority, output ready);
endinterface

interface apq_rsp_if #(
  parameter int unsigned TAG_BITS = 16,
  parameter int unsigned CNT_BITS = 7
);
  logic                        valid;
  logic                        ready;
  logic                        pop_valid;
  logic [TAG_BITS-1:0]         pop_tag;
  logic [apq_pkg::PRIO_W-1:0]  pop_priority;
  logic                        accepted;
  logic                        changed;
  logic [CNT_BITS-1:0]         removed_count;
  logic [CNT_BITS-1:0]         held_count;

  modport source (output valid, pop_valid, pop_tag, pop_priority, accepted, changed,
                  removed_count, held_count, input ready);
  modport sink (input valid, pop_valid, pop_tag, pop_priority, accepted, changed,
                removed_count, held_count, output ready);
endinterface

>>> rtl/aging_priority_queue_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                              Beat when
// req_i     in   kind, msg_tag, msg_priority                          valid && ready
// rsp_o     out  pop_valid, pop_tag, pop_priority, accepted,          valid && ready
//                changed, removed_count, held_count
// cfg       in   cfg_wdata_i (capacity_limit)                         cfg_we_i
//
// One request at a time; one entry per cycle through the dual-port entry memory.
// Insert shifts up each entry at or above its priority and then writes; pop reads
// the top entry; age and purge visit up to held_count; refused or empty: no walk.
// Reset clears the occupancy and sets capacity_limit to 64; no memory clearing pass.
// A response waits in its own register, so a stalled rsp_o holds only the next result.

module aging_priority_queue_top #(
  parameter int unsigned DEPTH    = 64,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  apq_req_if.sink                    req_i,
  apq_rsp_if.source                  rsp_o,
  input  logic                       cfg_we_i,
  input  logic [apq_pkg::CFG_W-1:0]  cfg_wdata_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > apq_pkg::CFG_W) ? CW : apq_pkg::CFG_W;
  localparam int unsigned PW = apq_pkg::PRIO_W;
  localparam int unsigned EW = TAG_BITS + PW;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;

  apq_pkg::state_e state_q, state_d;
  logic [CW-1:0]              occ_q, occ_d;
  logic [apq_pkg::CFG_W-1:0]  cap_q;
  logic [AW-1:0]              addr_q, addr_d;
  logic [CW-1:0]              zeros_q, zeros_d;
  logic                       counting_q, counting_d;
  apq_pkg::kind_e             kind_q, kind_d;
  logic [TAG_BITS-1:0]        tag_q, tag_d;
  logic [PW-1:0]              prio_q, prio_d;

  logic                r_pop_valid_q, r_pop_valid_d;
  logic [TAG_BITS-1:0] r_pop_tag_q, r_pop_tag_d;
  logic [PW-1:0]       r_pop_prio_q, r_pop_prio_d;
  logic                r_accepted_q, r_accepted_d;
  logic                r_changed_q, r_changed_d;
  logic [CW-1:0]       r_removed_q, r_removed_d;

  logic                rsp_valid_q;
  logic                rsp_load;
  logic [TAG_BITS-1:0] rsp_tag_q;
  logic [PW-1:0]       rsp_prio_q;
  logic                rsp_pop_valid_q, rsp_accepted_q, rsp_changed_q;
  logic [CW-1:0]       rsp_removed_q, rsp_held_q;

  logic [PW-1:0]       d_prio;
  logic [TAG_BITS-1:0] d_tag;
  logic [PW-1:0]       in_prio;
  logic                full;
  logic                at_end;
  logic [AW-1:0]       last_addr;

  assign d_prio    = rd_data_q[PW-1:0];
  assign d_tag     = rd_data_q[EW-1:PW];
  assign in_prio   = apq_pkg::sat_prio(req_i.msg_priority);
  assign full      = (occ_q == CW'(DEPTH)) || (MW'(occ_q) >= MW'(cap_q));
  assign at_end    = (CW'(addr_q) + CW'(1)) == occ_q;
  assign last_addr = AW'(occ_q - CW'(1));

  assign req_i.ready = (state_q == apq_pkg::ST_IDLE);

  always_comb begin
    state_d       = state_q;
    occ_d         = occ_q;
    addr_d        = addr_q;
    zeros_d       = zeros_q;
    counting_d    = counting_q;
    kind_d        = kind_q;
    tag_d         = tag_q;
    prio_d        = prio_q;
    r_pop_valid_d = r_pop_valid_q;
    r_pop_tag_d   = r_pop_tag_q;
    r_pop_prio_d  = r_pop_prio_q;
    r_accepted_d  = r_accepted_q;
    r_changed_d   = r_changed_q;
    r_removed_d   = r_removed_q;
    rd_en         = 1'b0;
    rd_addr       = addr_q;
    mem_we        = 1'b0;
    mem_wa        = addr_q;
    mem_wd        = rd_data_q;
    rsp_load      = 1'b0;

    unique case (state_q)
      apq_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          kind_d        = req_i.kind;
          tag_d         = req_i.msg_tag;
          prio_d        = in_prio;
          zeros_d       = '0;
          counting_d    = 1'b1;
          r_pop_valid_d = 1'b0;
          r_pop_tag_d   = '0;
          r_pop_prio_d  = '0;
          r_accepted_d  = 1'b0;
          r_changed_d   = 1'b0;
          r_removed_d   = '0;
          state_d       = apq_pkg::ST_DONE;
          unique case (req_i.kind)
            apq_pkg::KIND_INSERT: begin
              if (!full) begin
                if (occ_q == '0) begin
                  mem_we       = 1'b1;
                  mem_wa       = '0;
                  mem_wd       = {req_i.msg_tag, in_prio};
                  occ_d        = occ_q + CW'(1);
                  r_accepted_d = 1'b1;
                end else begin
                  rd_en   = 1'b1;
                  rd_addr = last_addr;
                  addr_d  = last_addr;
                  state_d = apq_pkg::ST_WALK;
                end
              end
            end
            apq_pkg::KIND_POP: begin
              if (occ_q != '0) begin
                rd_en   = 1'b1;
                rd_addr = last_addr;
                addr_d  = last_addr;
                state_d = apq_pkg::ST_WALK;
              end
            end
            apq_pkg::KIND_AGE, apq_pkg::KIND_PURGE: begin
              if (occ_q != '0) begin
                rd_en   = 1'b1;
                rd_addr = '0;
                addr_d  = '0;
                state_d = apq_pkg::ST_WALK;
              end
            end
          endcase
        end
      end

      apq_pkg::ST_WALK: begin
        unique case (kind_q)
          apq_pkg::KIND_INSERT: begin
            mem_we = 1'b1;
            mem_wa = addr_q + AW'(1);
            if (d_prio >= prio_q) begin
              mem_wd = rd_data_q;
              if (addr_q == '0) begin
                state_d = apq_pkg::ST_PUT;
              end else begin
                rd_en   = 1'b1;
                rd_addr = addr_q - AW'(1);
                addr_d  = addr_q - AW'(1);
              end
            end else begin
              mem_wd       = {tag_q, prio_q};
              occ_d        = occ_q + CW'(1);
              r_accepted_d = 1'b1;
              state_d      = apq_pkg::ST_DONE;
            end
          end
          apq_pkg::KIND_POP: begin
            occ_d         = occ_q - CW'(1);
            r_pop_valid_d = 1'b1;
            r_pop_tag_d   = d_tag;
            r_pop_prio_d  = d_prio;
            state_d       = apq_pkg::ST_DONE;
          end
          apq_pkg::KIND_AGE: begin
            if (d_prio >= apq_pkg::TOP_PRIORITY) begin
              state_d = apq_pkg::ST_DONE;
            end else begin
              if (d_prio != apq_pkg::ZERO_PRIORITY) begin
                mem_we      = 1'b1;
                mem_wa      = addr_q;
                mem_wd      = {d_tag, d_prio - PW'(1)};
                r_changed_d = 1'b1;
              end
              if (at_end) begin
                state_d = apq_pkg::ST_DONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = addr_q + AW'(1);
                addr_d  = addr_q + AW'(1);
              end
            end
          end
          apq_pkg::KIND_PURGE: begin
            priority if (counting_q && d_prio == apq_pkg::ZERO_PRIORITY) begin
              zeros_d = zeros_q + CW'(1);
              if (at_end) begin
                occ_d       = '0;
                r_removed_d = zeros_q + CW'(1);
                r_changed_d = 1'b1;
                state_d     = apq_pkg::ST_DONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = addr_q + AW'(1);
                addr_d  = addr_q + AW'(1);
              end
            end else if (zeros_q == '0) begin
              state_d = apq_pkg::ST_DONE;
            end else begin
              counting_d = 1'b0;
              mem_we     = 1'b1;
              mem_wa     = addr_q - zeros_q[AW-1:0];
              mem_wd     = rd_data_q;
              if (at_end) begin
                occ_d       = occ_q - zeros_q;
                r_removed_d = zeros_q;
                r_changed_d = 1'b1;
                state_d     = apq_pkg::ST_DONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = addr_q + AW'(1);
                addr_d  = addr_q + AW'(1);
              end
            end
          end
        endcase
      end

      apq_pkg::ST_PUT: begin
        mem_we       = 1'b1;
        mem_wa       = addr_q;
        mem_wd       = {tag_q, prio_q};
        occ_d        = occ_q + CW'(1);
        r_accepted_d = 1'b1;
        state_d      = apq_pkg::ST_DONE;
      end

      apq_pkg::ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = apq_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apq_pkg::ST_IDLE;
      occ_q       <= '0;
      cap_q       <= apq_pkg::CAP_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q        <= addr_d;
    zeros_q       <= zeros_d;
    counting_q    <= counting_d;
    kind_q        <= kind_d;
    tag_q         <= tag_d;
    prio_q        <= prio_d;
    r_pop_valid_q <= r_pop_valid_d;
    r_pop_tag_q   <= r_pop_tag_d;
    r_pop_prio_q  <= r_pop_prio_d;
    r_accepted_q  <= r_accepted_d;
    r_changed_q   <= r_changed_d;
    r_removed_q   <= r_removed_d;
    if (rsp_load) begin
      rsp_pop_valid_q <= r_pop_valid_q;
      rsp_tag_q       <= r_pop_tag_q;
      rsp_prio_q      <= r_pop_prio_q;
      rsp_accepted_q  <= r_accepted_q;
      rsp_changed_q   <= r_changed_q;
      rsp_removed_q   <= r_removed_q;
      rsp_held_q      <= occ_q;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.pop_valid     = rsp_pop_valid_q;
  assign rsp_o.pop_tag       = rsp_tag_q;
  assign rsp_o.pop_priority  = rsp_prio_q;
  assign rsp_o.accepted      = rsp_accepted_q;
  assign rsp_o.changed       = rsp_changed_q;
  assign rsp_o.removed_count = rsp_removed_q;
  assign rsp_o.held_count    = rsp_held_q;

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_walk_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == apq_pkg::ST_WALK |-> CW'(addr_q) < occ_q)
    else $error("walk address beyond held entries");

  a_rsp_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.pop_valid |-> !rsp_o.accepted && !rsp_o.changed)
    else $error("pop response carries insert or change flags");

  a_idle_occ : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == apq_pkg::ST_DONE && $past(state_q) == apq_pkg::ST_DONE |-> $stable(occ_q))
    else $error("occupancy moved while waiting to respond");

endmodule
